// ===== src/supcap_pkg.sv =====
package supcap_pkg;

    // Config register indices
    typedef enum logic [2:0] {
        CFG_UVP_ENTER   = 3'd0,
        CFG_READY       = 3'd1,
        CFG_UVP_RELEASE = 3'd2,
        CFG_UVP_DELAY   = 3'd3,
        CFG_PMOS_LOW    = 3'd4,
        CFG_PMOS_ON     = 3'd5,
        CFG_PMOS_OFF    = 3'd6
    } t_cfg_idx;

    localparam logic [15:0] RST_UVP_ENTER_MV    = 16'd8000;
    localparam logic [15:0] RST_READY_MV        = 16'd10000;
    localparam logic [15:0] RST_UVP_RELEASE_MV  = 16'd10000;
    localparam logic [9:0]  RST_UVP_DELAY_TICKS = 10'd1000;
    localparam logic [14:0] RST_PMOS_LOW_MA     = 15'd500;
    localparam logic [14:0] RST_PMOS_ON_MA      = 15'd1000;
    localparam logic [7:0]  RST_PMOS_OFF_TICKS  = 8'd200;

    localparam logic [9:0] UVP_CNT_MAX  = 10'd1023;
    localparam logic [7:0] PMOS_CNT_MAX = 8'd255;

    typedef struct packed {
        logic [15:0] uvp_enter_mv;
        logic [15:0] ready_mv;
        logic [15:0] uvp_release_mv;
        logic [9:0]  uvp_delay_ticks;
        logic [14:0] pmos_low_ma;
        logic [14:0] pmos_on_ma;
        logic [7:0]  pmos_off_ticks;
    } t_cfg;

    typedef struct packed {
        logic [15:0]        vcap_mv;
        logic signed [15:0] ibat_ma;
        logic               host_request;
        logic               host_move;
    } t_sample;

    typedef struct packed {
        logic cap_ready;
        logic charge_mode;
        logic discharge_mode;
        logic converter_enable;
        logic uvp_latched;
        logic pmos_on;
    } t_flags;

    typedef struct packed {
        t_flags     flags;
        logic [9:0] uvp_count;
        logic [7:0] pmos_count;
    } t_state;

    localparam t_flags RST_FLAGS = '{
        cap_ready:        1'b0,
        charge_mode:      1'b1,
        discharge_mode:   1'b0,
        converter_enable: 1'b0,
        uvp_latched:      1'b0,
        pmos_on:          1'b0
    };

endpackage

// ===== src/supcap_cfg.sv =====
module supcap_cfg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    output supcap_pkg::t_cfg   o_cfg
);
    import supcap_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_UVP_ENTER:   n_cfg.uvp_enter_mv    = i_cfg_data;
                CFG_READY:       n_cfg.ready_mv        = i_cfg_data;
                CFG_UVP_RELEASE: n_cfg.uvp_release_mv  = i_cfg_data;
                CFG_UVP_DELAY:   n_cfg.uvp_delay_ticks = i_cfg_data[9:0];
                CFG_PMOS_LOW:    n_cfg.pmos_low_ma     = i_cfg_data[14:0];
                CFG_PMOS_ON:     n_cfg.pmos_on_ma      = i_cfg_data[14:0];
                CFG_PMOS_OFF:    n_cfg.pmos_off_ticks  = i_cfg_data[7:0];
                default:         n_cfg = r_cfg;  // unused index, ignored
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.uvp_enter_mv    <= RST_UVP_ENTER_MV;
            r_cfg.ready_mv        <= RST_READY_MV;
            r_cfg.uvp_release_mv  <= RST_UVP_RELEASE_MV;
            r_cfg.uvp_delay_ticks <= RST_UVP_DELAY_TICKS;
            r_cfg.pmos_low_ma     <= RST_PMOS_LOW_MA;
            r_cfg.pmos_on_ma      <= RST_PMOS_ON_MA;
            r_cfg.pmos_off_ticks  <= RST_PMOS_OFF_TICKS;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== src/supcap_state.sv =====
module supcap_state (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  supcap_pkg::t_sample i_sample,
    input  supcap_pkg::t_cfg    i_cfg,
    output supcap_pkg::t_flags  o_next_flags
);
    import supcap_pkg::*;

    t_state r_st;
    t_state n_st;

    logic [9:0] uvp_inc;
    logic [7:0] pmos_inc;
    logic       v_low;
    logic       v_high;
    logic       ibat_low;
    logic       ibat_high;
    logic       v_release;

    assign v_low     = i_sample.vcap_mv < i_cfg.uvp_enter_mv;
    assign v_high    = i_sample.vcap_mv > i_cfg.ready_mv;
    assign v_release = i_sample.vcap_mv >= i_cfg.uvp_release_mv;
    assign ibat_low  = i_sample.ibat_ma < $signed({1'b0, i_cfg.pmos_low_ma});
    assign ibat_high = i_sample.ibat_ma >= $signed({1'b0, i_cfg.pmos_on_ma});
    assign uvp_inc   = (r_st.uvp_count < UVP_CNT_MAX) ? r_st.uvp_count + 10'd1
                                                      : r_st.uvp_count;
    assign pmos_inc  = (r_st.pmos_count < PMOS_CNT_MAX) ? r_st.pmos_count + 8'd1
                                                        : r_st.pmos_count;

    always_comb begin
        n_st = r_st;

        // undervoltage debounce, ready hysteresis
        if (v_low && !r_st.flags.uvp_latched) begin
            n_st.flags.cap_ready = 1'b0;
            if (uvp_inc >= i_cfg.uvp_delay_ticks) begin
                n_st.flags.discharge_mode   = 1'b0;
                n_st.flags.converter_enable = 1'b0;
                n_st.flags.uvp_latched      = 1'b1;
                n_st.flags.pmos_on          = 1'b0;
                n_st.uvp_count              = '0;
            end else begin
                n_st.uvp_count = uvp_inc;
            end
        end else if (v_high && !r_st.flags.uvp_latched) begin
            n_st.uvp_count       = '0;
            n_st.flags.cap_ready = 1'b1;
        end

        // mode select
        if (n_st.flags.cap_ready && i_sample.host_request && !n_st.flags.uvp_latched) begin
            n_st.flags.discharge_mode   = 1'b1;
            n_st.flags.converter_enable = i_sample.host_move;
        end else begin
            n_st.flags.discharge_mode = 1'b0;
        end
        if (!n_st.flags.discharge_mode && !n_st.flags.uvp_latched) begin
            n_st.flags.charge_mode      = 1'b1;
            n_st.flags.converter_enable = !i_sample.host_move;
        end else begin
            n_st.flags.charge_mode = 1'b0;
        end

        // PMOS on threshold, off delay
        if (ibat_low || (r_st.pmos_count != '0)) begin
            if (pmos_inc >= i_cfg.pmos_off_ticks) begin
                n_st.flags.pmos_on = 1'b0;
                n_st.pmos_count    = '0;
            end else begin
                n_st.pmos_count = pmos_inc;
            end
        end else if (ibat_high) begin
            n_st.flags.pmos_on = 1'b1;
            n_st.pmos_count    = '0;
        end

        // latched undervoltage overrides ready and PMOS until release
        if (n_st.flags.uvp_latched) begin
            n_st.flags.cap_ready = 1'b0;
            n_st.flags.pmos_on   = !i_sample.host_move;
            if (v_release && !i_sample.host_request) begin
                n_st.flags.uvp_latched = 1'b0;
                n_st.flags.charge_mode = 1'b1;
                n_st.flags.cap_ready   = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.flags      <= RST_FLAGS;
            r_st.uvp_count  <= '0;
            r_st.pmos_count <= '0;
        end else if (i_step) begin
            r_st <= n_st;
        end
    end

    assign o_next_flags = n_st.flags;

`ifndef SYNTHESIS
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_st))
        else $error("state moved without a step");
    a_mode_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_st.flags.charge_mode && r_st.flags.discharge_mode))
        else $error("charge and discharge both set");
    a_latch_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.flags.uvp_latched |-> (!r_st.flags.cap_ready && r_st.uvp_count == '0
                                    && !r_st.flags.discharge_mode))
        else $error("latched undervoltage with ready, discharge or live debounce");
`endif

endmodule

// ===== src/supercap_mode_supervisor.sv =====
// Path: a word accepted into the input register is computed and stored in the
//   result register shown on o_valid; a held result register stalls the step.
// Throughput: one word per cycle unless i_ready stalls; each register holds one.
// Reset (i_rst_n low, synchronous): pipeline emptied, flags and counters cleared
//   (charge mode set), configuration back to its default thresholds.
module supercap_mode_supervisor (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration write port
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    // tick input
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [15:0]        i_vcap_mv,
    input  logic signed [15:0] i_ibat_ma,
    input  logic               i_host_request,
    input  logic               i_host_move,
    // result output
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_cap_ready,
    output logic               o_charge_mode,
    output logic               o_discharge_mode,
    output logic               o_converter_enable,
    output logic               o_uvp_latched,
    output logic               o_pmos_on
);
    import supcap_pkg::*;

    t_cfg    cfg;
    t_sample r_in;
    logic    r_in_valid;
    t_flags  r_out;
    logic    r_out_valid;
    t_flags  next_flags;
    logic    step;
    logic    in_acc;

    // Config registers
    supcap_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // A step runs when a sampled word waits and the result slot is free or
    // being emptied this cycle. The supervisor state moves on only then, so
    // each word sees exactly the state its predecessor left.
    assign step    = r_in_valid && (!r_out_valid || i_ready);
    // The input slot takes a new word whenever it is empty or being drained.
    assign o_ready = !r_in_valid || step;
    assign in_acc  = i_valid && o_ready;

    supcap_state u_state (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_sample     (r_in),
        .i_cfg        (cfg),
        .o_next_flags (next_flags)
    );

    // Input register: payload needs no reset
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in.vcap_mv      <= i_vcap_mv;
            r_in.ibat_ma      <= i_ibat_ma;
            r_in.host_request <= i_host_request;
            r_in.host_move    <= i_host_move;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    // Result register: flags after the tick
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= next_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_cap_ready        = r_out.cap_ready;
    assign o_charge_mode      = r_out.charge_mode;
    assign o_discharge_mode   = r_out.discharge_mode;
    assign o_converter_enable = r_out.converter_enable;
    assign o_uvp_latched      = r_out.uvp_latched;
    assign o_pmos_on          = r_out.pmos_on;

`ifndef SYNTHESIS
    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !i_ready) |-> !o_ready)
        else $error("input taken while both stages are stalled");
    a_step_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> o_valid)
        else $error("step gave no result");
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_in_valid && !(o_valid && !i_ready)) |=> !o_valid)
        else $error("result appeared without a word");
`endif

endmodule
